// ----- hdl/tdc_pkg.sv -----
// Shared types, constants and calendar helpers for the time-of-day calendar counter.
// No dependencies; every other file in hdl imports this package.
package tdc_pkg;

  // operation selector
  localparam logic [1:0] FN_ADVANCE  = 2'd0;
  localparam logic [1:0] FN_SET_TIME = 2'd1;
  localparam logic [1:0] FN_SET_DATE = 2'd2;
  localparam logic [1:0] FN_READ     = 2'd3;

  // divider operand source
  localparam logic [1:0] SRC_ADV = 2'd0;  // advance seconds / seconds per day
  localparam logic [1:0] SRC_SEC = 2'd1;  // seconds of day / 60
  localparam logic [1:0] SRC_MIN = 2'd2;  // minutes of day / 60

  localparam int SEC_PER_DAY  = 86400;
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_MIN  = 60;
  localparam int MONTHS       = 12;

  localparam int DIV_W  = 32;                  // dividend width
  localparam int DSOR_W = $clog2(SEC_PER_DAY); // 17 bits holds a remainder by one day
  localparam int QUO_W  = 16;                  // largest quotient is 49710 days

  // reciprocal division:
  //   n / 86400 = ((n >> 7) * RCP_DAY) >> 35 for any 32-bit n (86400 = 128 * 675)
  //   n / 60    = ((n >> 2) * RCP_MIN) >> 19 for any 17-bit n (60 = 4 * 15)
  localparam int RCP_AW     = 25;
  localparam int RCP_MW     = 26;
  localparam int RCP_PW     = RCP_AW + RCP_MW;
  localparam int RCP_SH_DAY = 35;
  localparam int RCP_SH_MIN = 19;
  localparam logic [RCP_MW-1:0] RCP_DAY = 26'd50903317;
  localparam logic [RCP_MW-1:0] RCP_MIN = 26'd34953;

  // 25^-1 mod 2^16, and the largest 16-bit quotient by 25
  localparam logic [15:0] INV25   = 16'd23593;
  localparam logic [15:0] LIM25   = 16'd2621;

  typedef struct packed {
    logic       load_time;
    logic       load_date;
    logic       div_go;
    logic [1:0] div_src;
    logic       add_rem;
    logic       step_day;
    logic       cap_sec;
    logic       cap_hm;
  } tdc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic days_zero;
  } tdc_sts_t;

  // Gregorian leap test. Divisibility by 25 uses the modular inverse:
  // y is a multiple of 25 exactly when y * 25^-1 (mod 2^16) <= 65535 / 25.
  function automatic logic is_leap(input logic [15:0] y);
    logic [31:0] prod;
    logic        div25;
    prod  = 32'(y) * 32'(INV25);
    div25 = (prod[15:0] <= LIM25);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  // month length; months without meaning count as 31 days
  function automatic logic [4:0] month_len(input logic [15:0] y, input logic [3:0] m);
    logic [4:0] len;
    if (m == 4'd2) begin
      len = is_leap(y) ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

// ----- hdl/tdc_div.sv -----
// Constant divider by seconds per day or by sixty, divisor chosen at start, using
// reciprocal multiplication, registered stage by stage. Depends on tdc_pkg.
module tdc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic                      by_day,
  input  logic [tdc_pkg::DIV_W-1:0] dividend,
  output logic                      done,
  output logic [tdc_pkg::DIV_W-1:0] quotient,
  output logic [tdc_pkg::DSOR_W-1:0] remainder
);
  import tdc_pkg::*;

  logic [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic              by_day_r, by_day_nxt;
  logic [RCP_PW-1:0] prod_r, prod_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [DSOR_W-1:0] rem_r, rem_nxt;
  logic              ld_r;    // operands loaded, product next
  logic              mul_r;   // product ready, result next
  logic              done_r;
  logic [RCP_AW-1:0] rcp_a;
  logic [RCP_MW-1:0] rcp_m;
  logic [QUO_W-1:0]  quo_c;
  logic [DIV_W-1:0]  quo_x_dsor;

  // reciprocal operands, quotient slice and back-multiplied quotient
  always_comb begin
    rcp_a = by_day_r ? dvd_r[DIV_W-1:DIV_W-RCP_AW] : RCP_AW'(dvd_r[DSOR_W-1:2]);
    rcp_m = by_day_r ? RCP_DAY : RCP_MIN;
    quo_c = by_day_r ? prod_r[RCP_PW-1:RCP_SH_DAY]
                     : prod_r[RCP_SH_MIN+QUO_W-1:RCP_SH_MIN];
    quo_x_dsor = by_day_r ? (DIV_W'(quo_c) * DIV_W'(SEC_PER_DAY))
                          : (DIV_W'(quo_c) * DIV_W'(SEC_PER_MIN));
  end

  always_comb begin
    dvd_nxt    = dvd_r;
    by_day_nxt = by_day_r;
    prod_nxt   = prod_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    if (go) begin
      dvd_nxt    = dividend;
      by_day_nxt = by_day;
    end
    if (ld_r) begin
      prod_nxt = RCP_PW'(rcp_a) * RCP_PW'(rcp_m);
    end
    if (mul_r) begin
      quo_nxt = quo_c;
      rem_nxt = DSOR_W'(dvd_r - quo_x_dsor);
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r   <= 1'b0;
      mul_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      ld_r   <= go;
      mul_r  <= ld_r;
      done_r <= mul_r;
    end
  end

  // operands and results
  always_ff @(posedge clk) begin
    dvd_r    <= dvd_nxt;
    by_day_r <= by_day_nxt;
    prod_r   <= prod_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = DIV_W'(quo_r);
  assign remainder = rem_r;

endmodule

// ----- hdl/tdc_dp.sv -----
// Datapath: time and calendar registers, day stepper, divider and result capture.
// Depends on tdc_pkg and tdc_div; driven by tdc_ctrl through tdc_cmd_t.
module tdc_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  tdc_pkg::tdc_cmd_t cmd,
  output tdc_pkg::tdc_sts_t sts,
  input  logic [31:0]       in_advance_seconds,
  input  logic [4:0]        in_set_hour,
  input  logic [5:0]        in_set_minute,
  input  logic [5:0]        in_set_second,
  input  logic [15:0]       in_set_year,
  input  logic [3:0]        in_set_month,
  input  logic [4:0]        in_set_day,
  output logic [4:0]        out_hour,
  output logic [5:0]        out_minute,
  output logic [5:0]        out_second,
  output logic [15:0]       out_year,
  output logic [3:0]        out_month,
  output logic [4:0]        out_day
);
  import tdc_pkg::*;

  logic [16:0] ds_r, ds_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [15:0] year_r, year_nxt;
  logic [15:0] days_r, days_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;

  logic [DIV_W-1:0]  div_dvd, div_q;
  logic [DSOR_W-1:0] div_rem;
  logic              div_done;

  logic [17:0] t_sum;
  logic [16:0] t_load;
  logic [4:0]  mlen;
  logic [5:0]  d_inc;
  logic [4:0]  m_inc;

  // divider operand select
  always_comb begin
    case (cmd.div_src)
      SRC_ADV: div_dvd = in_advance_seconds;
      SRC_SEC: div_dvd = DIV_W'(ds_r);
      SRC_MIN: div_dvd = div_q;
      default: div_dvd = div_q;
    endcase
  end

  tdc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (cmd.div_go),
    .by_day    (cmd.div_src == SRC_ADV),
    .dividend  (div_dvd),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // time load, remainder add and day step terms
  always_comb begin
    t_load = 17'(in_set_hour) * 17'(SEC_PER_HOUR)
           + 17'(in_set_minute) * 17'(SEC_PER_MIN)
           + 17'(in_set_second);
    t_sum  = {1'b0, ds_r} + {1'b0, div_rem};
    mlen   = month_len(year_r, month_r);
    d_inc  = {1'b0, day_r} + 6'd1;
    m_inc  = {1'b0, month_r} + 5'd1;
  end

  always_comb begin
    ds_nxt    = ds_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    days_nxt  = days_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;

    if (cmd.load_time) begin
      ds_nxt = t_load;
    end
    if (cmd.load_date) begin
      year_nxt  = in_set_year;
      month_nxt = in_set_month;
      day_nxt   = in_set_day;
    end

    // carry of the remainder past midnight counts one more day
    if (cmd.add_rem) begin
      if (t_sum >= 18'(SEC_PER_DAY)) begin
        ds_nxt   = 17'(t_sum - 18'(SEC_PER_DAY));
        days_nxt = div_q[15:0] + 16'd1;
      end else begin
        ds_nxt   = t_sum[16:0];
        days_nxt = div_q[15:0];
      end
    end

    // one calendar day
    if (cmd.step_day) begin
      days_nxt = days_r - 16'd1;
      if (d_inc > {1'b0, mlen}) begin
        day_nxt = 5'd1;
        if (m_inc > 5'(MONTHS)) begin
          month_nxt = 4'd1;
          year_nxt  = year_r + 16'd1;
        end else begin
          month_nxt = m_inc[3:0];
        end
      end else begin
        day_nxt = d_inc[4:0];
      end
    end

    if (cmd.cap_sec) begin
      sec_nxt = div_rem[5:0];
    end
    if (cmd.cap_hm) begin
      min_nxt  = div_rem[5:0];
      hour_nxt = div_q[4:0];
    end
  end

  // clock and calendar state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ds_r    <= '0;
      day_r   <= 5'd27;
      month_r <= 4'd5;
      year_r  <= 16'd2009;
      days_r  <= '0;
    end else begin
      ds_r    <= ds_nxt;
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      days_r  <= days_nxt;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    sec_r  <= sec_nxt;
  end

  assign sts.div_done  = div_done;
  assign sts.days_zero = (days_r == 16'd0);

  assign out_hour   = hour_r;
  assign out_minute = min_r;
  assign out_second = sec_r;
  assign out_year   = year_r;
  assign out_month  = month_r;
  assign out_day    = day_r;

endmodule

// ----- hdl/tdc_ctrl.sv -----
// Controller: sequences accept, division, day stepping and the result strobe.
// Depends on tdc_pkg; drives tdc_dp through tdc_cmd_t.
module tdc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_func,
  input  tdc_pkg::tdc_sts_t sts,
  output tdc_pkg::tdc_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import tdc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DAYDIV = 3'd1;
  localparam logic [2:0] S_STEP   = 3'd2;
  localparam logic [2:0] S_SECDIV = 3'd3;
  localparam logic [2:0] S_MINDIV = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_STEP;
          case (in_func)
            FN_ADVANCE: begin
              cmd.div_go  = 1'b1;
              cmd.div_src = SRC_ADV;
              state_nxt   = S_DAYDIV;
            end
            FN_SET_TIME: cmd.load_time = 1'b1;
            FN_SET_DATE: cmd.load_date = 1'b1;
            FN_READ:     cmd.load_time = 1'b0;
            default:     cmd.load_time = 1'b0;
          endcase
        end
      end
      S_DAYDIV: begin
        if (sts.div_done) begin
          cmd.add_rem = 1'b1;
          state_nxt   = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.days_zero) begin
          cmd.div_go  = 1'b1;
          cmd.div_src = SRC_SEC;
          state_nxt   = S_SECDIV;
        end else begin
          cmd.step_day = 1'b1;
        end
      end
      S_SECDIV: begin
        cmd.div_src = SRC_MIN;
        if (sts.div_done) begin
          cmd.cap_sec = 1'b1;
          cmd.div_go  = 1'b1;
          state_nxt   = S_MINDIV;
        end
      end
      S_MINDIV: begin
        cmd.div_src = SRC_MIN;
        if (sts.div_done) begin
          cmd.cap_hm = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// ----- hdl/time_of_day_calendar_counter.sv -----
// Time-of-day calendar counter top level: controller plus datapath.
// Depends on tdc_pkg, tdc_ctrl, tdc_dp (and tdc_div below it).
//
// A command is taken when start is high and busy is low; exactly one result beat
// follows, shown on the out_ ports for one cycle while out_valid is high. The
// receiver cannot stall, so it must take the beat in that cycle. Set time, set
// date and read divide the time of day by sixty twice, first the seconds and
// then the minutes, in the reciprocal divider; an advance first divides its
// seconds by one day, then steps the calendar one day per cycle through every
// whole day it carries (up to 49711 for the largest advance), and then does the
// same two divisions. Reset gives midnight on day 27, month 5, year 2009.
module time_of_day_calendar_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_advance_seconds,
  input  logic [4:0]  in_set_hour,
  input  logic [5:0]  in_set_minute,
  input  logic [5:0]  in_set_second,
  input  logic [15:0] in_set_year,
  input  logic [3:0]  in_set_month,
  input  logic [4:0]  in_set_day,
  output logic        out_valid,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [15:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day
);
  import tdc_pkg::*;

  tdc_cmd_t cmd;
  tdc_sts_t sts;

  tdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  tdc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_advance_seconds (in_advance_seconds),
    .in_set_hour        (in_set_hour),
    .in_set_minute      (in_set_minute),
    .in_set_second      (in_set_second),
    .in_set_year        (in_set_year),
    .in_set_month       (in_set_month),
    .in_set_day         (in_set_day),
    .out_hour           (out_hour),
    .out_minute         (out_minute),
    .out_second         (out_second),
    .out_year           (out_year),
    .out_month          (out_month),
    .out_day            (out_day)
  );

endmodule
